// ===== hw/rtl/gcd_pkg.sv =====
// ----------------------------------------------------------------------------
// gcd_pkg: shared constants and table builders for the great-circle block
// Fixed-point formats, CORDIC arctangent table and gain, built at elaboration.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int ANG_W      = 33;  // sign-extended angle width at the CORDIC input
  localparam int DEG_Q      = 55;  // CORDIC angle: degrees, Q55
  localparam int SQRT_STEPS = 32;  // one result bit per step
  localparam int MUL_LAT    = 5;
  localparam int RAD_W      = 25;
  localparam int DIST_W     = 25;

  localparam logic signed [63:0] ONE_Q60 = 64'sd1 <<< 60;
  localparam logic signed [63:0] DEG180  = 64'sd180 <<< DEG_Q;
  localparam logic signed [63:0] DIST_MAX = 64'sd33554431;
  localparam logic [RAD_W-1:0]   RADIUS_ALL = '1;
  // metres per degree, Q27
  localparam logic signed [63:0] M_PER_DEG = (64'sd11118957696 <<< 27) / 64'sd100000;

  // shift-subtract division, elaboration only
  function automatic logic [63:0] udiv_f(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], n[k]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // exact product, magnitude truncated after the shift
  function automatic logic signed [63:0] mul_shift_f(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input int sh);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    logic [63:0]  r;
    ua = a[63] ? 64'(-a) : 64'(a);
    ub = b[63] ? 64'(-b) : 64'(b);
    p  = {64'd0, ua} * {64'd0, ub};
    p  = p >> sh;
    r  = {1'b0, p[62:0]};
    return (a[63] != b[63]) ? $signed(-r) : $signed(r);
  endfunction

  function automatic logic signed [63:0] atan_inv_q62_f(input logic [63:0] n);
    logic [63:0]        t;
    logic [63:0]        term;
    logic [63:0]        k;
    logic signed [63:0] sum;
    t   = udiv_f(64'd1 << 62, n);
    sum = '0;
    k   = '0;
    for (int j = 0; j < 64; j++) begin
      if (t != 64'd0) begin
        term = udiv_f(t, 2 * k + 64'd1);
        if (k[0]) sum = sum - $signed(term);
        else      sum = sum + $signed(term);
        t = udiv_f(t, n * n);
        k = k + 64'd1;
      end
    end
    return sum;
  endfunction

  // 180/pi in Q56
  function automatic logic signed [63:0] e56_f();
    logic signed [63:0] quarter;
    logic [63:0]        r;
    logic [63:0]        q;
    quarter = 4 * atan_inv_q62_f(64'd5) - atan_inv_q62_f(64'd239);
    r = 64'd45;
    q = '0;
    for (int k = 0; k < 118; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= 64'(quarter)) begin
        r    = r - 64'(quarter);
        q[0] = 1'b1;
      end
    end
    return $signed(q);
  endfunction

  localparam logic signed [63:0] E56 = e56_f();

  // atan(2^-i) in degrees, Q55
  function automatic logic signed [63:0] atan_deg_f(input int i);
    logic signed [63:0] sum;
    logic [63:0]        term;
    int                 e;
    sum = '0;
    if (i == 0) return 64'sd45 <<< DEG_Q;
    for (int k = 0; k < 31; k++) begin
      e = 60 - i * (2 * k + 1);
      if (e >= 0) begin
        term = udiv_f(64'd1 << e, 64'(2 * k + 1));
        if (k % 2 == 1) sum = sum - $signed(term);
        else            sum = sum + $signed(term);
      end
    end
    return mul_shift_f(sum, E56, 61);
  endfunction

  // 1/gain in Q60 for a given stage count
  function automatic logic signed [63:0] inv_gain_f(input int stages);
    logic signed [63:0] p;
    logic signed [63:0] y;
    logic signed [63:0] t;
    p = ONE_Q60;
    for (int i = 0; i < stages; i++) begin
      if (2 * i < 63) p = p + (p >>> (2 * i));
    end
    y = 64'sd5 <<< 57;
    for (int k = 0; k < 10; k++) begin
      t = mul_shift_f(y, y, 60);
      t = mul_shift_f(p, t, 60);
      t = 3 * ONE_Q60 - t;
      y = mul_shift_f(y, t, 61);
    end
    return y;
  endfunction

endpackage

// ===== hw/rtl/gcd_mul.sv =====
// ----------------------------------------------------------------------------
// gcd_mul: pipelined signed 64x64 multiply with truncating right shift
// Four 32x32 partial products, summed over two stages, sign applied last.
// ----------------------------------------------------------------------------
module gcd_mul #(
  parameter int SHIFT  = 60,
  parameter int SIDE_W = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [63:0]      a,
  input  logic signed [63:0]      b,
  input  logic [SIDE_W-1:0]       in_side,
  output logic                    out_valid,
  output logic signed [63:0]      p,
  output logic [SIDE_W-1:0]       out_side
);

  localparam int LAT = gcd_pkg::MUL_LAT;

  logic [63:0]  ua, ub;
  logic [3:0]   neg;
  logic [63:0]  p00, p01, p10, p11;
  logic [64:0]  mid;
  logic [63:0]  p00_d, p11_d;
  logic [127:0] full;
  logic [127:0] sh;
  logic [63:0]  mag;
  logic [LAT-1:0]    vp;
  logic [SIDE_W-1:0] sp [LAT];

  assign sh  = full >> SHIFT;
  assign mag = {1'b0, sh[62:0]};

  always_ff @(posedge clk) begin
    ua     <= a[63] ? 64'(-a) : 64'(a);
    ub     <= b[63] ? 64'(-b) : 64'(b);
    neg[0] <= a[63] ^ b[63];
    p00    <= 64'(ua[31:0]) * 64'(ub[31:0]);
    p01    <= 64'(ua[31:0]) * 64'(ub[63:32]);
    p10    <= 64'(ua[63:32]) * 64'(ub[31:0]);
    p11    <= 64'(ua[63:32]) * 64'(ub[63:32]);
    neg[1] <= neg[0];
    mid    <= 65'(p01) + 65'(p10);
    p00_d  <= p00;
    p11_d  <= p11;
    neg[2] <= neg[1];
    full   <= {p11_d, p00_d} + (128'(mid) << 32);
    neg[3] <= neg[2];
    p      <= neg[3] ? $signed(-mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else begin
      vp <= {vp[LAT-2:0], in_valid};
    end
    sp[0] <= in_side;
    for (int k = 1; k < LAT; k++) sp[k] <= sp[k-1];
  end

  assign out_valid = vp[LAT-1];
  assign out_side  = sp[LAT-1];

endmodule

// ===== hw/rtl/gcd_sincos.sv =====
// ----------------------------------------------------------------------------
// gcd_sincos: angle reduction and rotation-mode CORDIC
// Reduces to [-180,180), folds into [-90,90], one CORDIC step per stage.
// ----------------------------------------------------------------------------
module gcd_sincos #(
  parameter int AFB    = 23,
  parameter int STAGES = 28,
  parameter int SIDE_W = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic signed [gcd_pkg::ANG_W-1:0] angle,
  input  logic [SIDE_W-1:0]              in_side,
  output logic                           out_valid,
  output logic signed [63:0]             sin_q,
  output logic signed [63:0]             cos_q,
  output logic [SIDE_W-1:0]              out_side
);

  localparam int LW  = AFB + 3;                 // bits below the 45-turn count
  localparam int HW  = gcd_pkg::ANG_W - LW;     // count of 8*2^AFB steps, signed
  localparam int VW  = HW + 5;
  localparam int RS  = VW + 6;
  localparam int RMW = RS - 5;
  localparam int PW  = VW + RMW;
  localparam int AW  = AFB + 10;
  localparam int LAT = STAGES + 4;

  localparam logic [RMW-1:0] RM   = RMW'(((64'd1 << RS) + 64'd44) / 64'd45);
  localparam logic [VW-1:0]  VOFF = VW'(45) << (HW - 1);
  localparam logic [VW-1:0]  M45  = VW'(45);
  localparam logic [AW-2:0]  HALF_U = (AW-1)'(180) << AFB;
  localparam logic signed [AW-1:0] FULL_S  = AW'(360) <<< AFB;
  localparam logic signed [AW-1:0] HALF_S  = AW'(180) <<< AFB;
  localparam logic signed [AW-1:0] RIGHT_S = AW'(90) <<< AFB;
  localparam logic signed [63:0]   INV_GAIN = gcd_pkg::inv_gain_f(STAGES);

  // reduction stage 1: quotient by 45 through a reciprocal
  logic [VW-1:0]  v0;
  logic [PW-1:0]  prod0;
  logic [VW-1:0]  v1;
  logic [HW-1:0]  q1;
  logic [LW-1:0]  lo1;

  assign v0    = VW'($signed(angle[gcd_pkg::ANG_W-1:LW])) + VOFF;
  assign prod0 = PW'(v0) * PW'(RM);

  // reduction stage 2: remainder, recentre
  logic [VW-1:0]        rem1;
  logic [AW-2:0]        red1;
  logic signed [AW-1:0] ar2;

  assign rem1 = v1 - VW'(q1) * M45;
  assign red1 = {rem1[5:0], lo1};

  // reduction stage 3: fold to the right half-plane
  logic signed [63:0] z3;
  logic               neg3;

  always_ff @(posedge clk) begin
    v1  <= v0;
    q1  <= prod0[RS+HW-1:RS];
    lo1 <= angle[LW-1:0];
    ar2 <= (red1 >= HALF_U) ? $signed({1'b0, red1}) - FULL_S : $signed({1'b0, red1});
    if (ar2 > RIGHT_S) begin
      z3   <= 64'(ar2 - HALF_S) <<< (gcd_pkg::DEG_Q - AFB);
      neg3 <= 1'b1;
    end else if (ar2 < -RIGHT_S) begin
      z3   <= 64'(ar2 + HALF_S) <<< (gcd_pkg::DEG_Q - AFB);
      neg3 <= 1'b1;
    end else begin
      z3   <= 64'(ar2) <<< (gcd_pkg::DEG_Q - AFB);
      neg3 <= 1'b0;
    end
  end

  // CORDIC steps
  logic signed [63:0] xr [STAGES];
  logic signed [63:0] yr [STAGES];
  logic signed [63:0] zr [STAGES];
  logic               nr [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [63:0] ATAN = gcd_pkg::atan_deg_f(i);
    logic signed [63:0] xi, yi, zi;
    logic               ni;
    if (i == 0) begin : g_first
      assign xi = INV_GAIN;
      assign yi = '0;
      assign zi = z3;
      assign ni = neg3;
    end else begin : g_next
      assign xi = xr[i-1];
      assign yi = yr[i-1];
      assign zi = zr[i-1];
      assign ni = nr[i-1];
    end
    always_ff @(posedge clk) begin
      if (zi >= 0) begin
        xr[i] <= xi - (yi >>> i);
        yr[i] <= yi + (xi >>> i);
        zr[i] <= zi - ATAN;
      end else begin
        xr[i] <= xi + (yi >>> i);
        yr[i] <= yi - (xi >>> i);
        zr[i] <= zi + ATAN;
      end
      nr[i] <= ni;
    end
  end

  always_ff @(posedge clk) begin
    sin_q <= nr[STAGES-1] ? -yr[STAGES-1] : yr[STAGES-1];
    cos_q <= nr[STAGES-1] ? -xr[STAGES-1] : xr[STAGES-1];
  end

  logic [LAT-1:0]    vp;
  logic [SIDE_W-1:0] sp [LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else begin
      vp <= {vp[LAT-2:0], in_valid};
    end
    sp[0] <= in_side;
    for (int k = 1; k < LAT; k++) sp[k] <= sp[k-1];
  end

  assign out_valid = vp[LAT-1];
  assign out_side  = sp[LAT-1];

endmodule

// ===== hw/rtl/gcd_acos.sv =====
// ----------------------------------------------------------------------------
// gcd_acos: arc cosine in degrees Q55 from a clamped Q60 cosine
// (1-c)(1+c), digit-by-digit square root, then vectoring-mode CORDIC.
// ----------------------------------------------------------------------------
module gcd_acos #(
  parameter int STAGES = 28,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [63:0]  cval,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic signed [63:0]  angle,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int SQ = gcd_pkg::SQRT_STEPS;

  logic               m_valid;
  logic signed [63:0] m_p;
  logic signed [63:0] m_c;
  logic [SIDE_W-1:0]  m_side;

  gcd_mul #(.SHIFT(60), .SIDE_W(64 + SIDE_W)) u_sq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .a         (gcd_pkg::ONE_Q60 - cval),
    .b         (gcd_pkg::ONE_Q60 + cval),
    .in_side   ({cval, in_side}),
    .out_valid (m_valid),
    .p         (m_p),
    .out_side  ({m_c, m_side})
  );

  // square root of 4q, one bit per stage
  logic [63:0]        vr [SQ];
  logic [63:0]        rr [SQ];
  logic signed [63:0] cr [SQ];
  logic [SIDE_W-1:0]  sr [SQ];
  logic [SQ-1:0]      svp;

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
    logic [63:0] vin, rin, t;
    if (k == 0) begin : g_first
      assign vin = {m_p[61:0], 2'b00};
      assign rin = '0;
    end else begin : g_next
      assign vin = vr[k-1];
      assign rin = rr[k-1];
    end
    assign t = rin + BITV;
    always_ff @(posedge clk) begin
      if (vin >= t) begin
        vr[k] <= vin - t;
        rr[k] <= (rin >> 1) + BITV;
      end else begin
        vr[k] <= vin;
        rr[k] <= rin >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      svp <= '0;
    end else begin
      svp <= {svp[SQ-2:0], m_valid};
    end
    cr[0] <= m_c;
    sr[0] <= m_side;
    for (int k = 1; k < SQ; k++) begin
      cr[k] <= cr[k-1];
      sr[k] <= sr[k-1];
    end
  end

  // vectoring CORDIC on (|c|, sqrt(1-c^2))
  logic signed [63:0] xr [STAGES];
  logic signed [63:0] yr [STAGES];
  logic signed [63:0] zr [STAGES];
  logic               nr [STAGES];
  logic [SIDE_W-1:0]  dr [STAGES];
  logic [STAGES-1:0]  cvp;
  logic signed [63:0] c_last;

  assign c_last = cr[SQ-1];

  for (genvar i = 0; i < STAGES; i++) begin : g_vec
    localparam logic signed [63:0] ATAN = gcd_pkg::atan_deg_f(i);
    logic signed [63:0] xi, yi, zi;
    if (i == 0) begin : g_first
      assign xi = c_last[63] ? -c_last : c_last;
      assign yi = $signed(rr[SQ-1] << 29);
      assign zi = '0;
    end else begin : g_next
      assign xi = xr[i-1];
      assign yi = yr[i-1];
      assign zi = zr[i-1];
    end
    always_ff @(posedge clk) begin
      if (yi > 0) begin
        xr[i] <= xi + (yi >>> i);
        yr[i] <= yi - (xi >>> i);
        zr[i] <= zi + ATAN;
      end else begin
        xr[i] <= xi - (yi >>> i);
        yr[i] <= yi + (xi >>> i);
        zr[i] <= zi - ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cvp <= '0;
    end else begin
      cvp <= {cvp[STAGES-2:0], svp[SQ-1]};
    end
    nr[0] <= c_last[63];
    dr[0] <= sr[SQ-1];
    for (int k = 1; k < STAGES; k++) begin
      nr[k] <= nr[k-1];
      dr[k] <= dr[k-1];
    end
  end

  // final: drop negative angle, mirror for negative cosine
  logic signed [63:0] zpos;
  assign zpos = zr[STAGES-1][63] ? 64'sd0 : zr[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cvp[STAGES-1];
    end
    angle    <= nr[STAGES-1] ? gcd_pkg::DEG180 - zpos : zpos;
    out_side <= dr[STAGES-1];
  end

endmodule

// ===== hw/rtl/great_circle_distance_coverage.sv =====
// ----------------------------------------------------------------------------
// great_circle_distance_coverage: distance between two points and radius test
// Throughput: one beat per cycle; busy never rises, every stage is registered.
// Depth is set by the two CORDIC chains, the 32-step square root and the
// multipliers. Results come out on a one-cycle done strobe.
// Reset: rst is synchronous; it clears every valid bit, so no stale done.
// ----------------------------------------------------------------------------
module great_circle_distance_coverage #(
  parameter int ANGLE_FRAC_BITS = 23,
  parameter int CORDIC_STAGES   = 28
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [30:0]            user_lat,
  input  logic signed [31:0]            user_lon,
  input  logic signed [30:0]            server_lat,
  input  logic signed [31:0]            server_lon,
  input  logic [gcd_pkg::RAD_W-1:0]     coverage_radius,
  output logic                          done,
  output logic [gcd_pkg::DIST_W-1:0]    distance_m,
  output logic                          in_coverage
);

  localparam int AW = gcd_pkg::ANG_W;
  localparam int SW = gcd_pkg::RAD_W + 1;   // {same point, radius}

  // pipeline never back-pressures
  assign busy = 1'b0;

  // entry stage: sign-extend, longitude difference, same-point check
  logic                 s0_valid;
  logic signed [AW-1:0] a_ul, a_sl, a_dl;
  logic [SW-1:0]        s0_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start;
    end
    a_ul    <= AW'(user_lat);
    a_sl    <= AW'(server_lat);
    a_dl    <= AW'(user_lon) - AW'(server_lon);
    s0_side <= {(user_lat == server_lat) && (user_lon == server_lon), coverage_radius};
  end

  // three sin/cos units in lock-step; only the first carries the beat
  logic               sc_valid;
  logic [SW-1:0]      sc_side;
  logic signed [63:0] s1, c1, s2, c2, ct;

  gcd_sincos #(.AFB(ANGLE_FRAC_BITS), .STAGES(CORDIC_STAGES), .SIDE_W(SW)) u_sc_u (
    .clk (clk), .rst (rst), .in_valid (s0_valid), .angle (a_ul), .in_side (s0_side),
    .out_valid (sc_valid), .sin_q (s1), .cos_q (c1), .out_side (sc_side)
  );

  gcd_sincos #(.AFB(ANGLE_FRAC_BITS), .STAGES(CORDIC_STAGES), .SIDE_W(1)) u_sc_s (
    .clk (clk), .rst (rst), .in_valid (s0_valid), .angle (a_sl), .in_side (1'b0),
    .out_valid (), .sin_q (s2), .cos_q (c2), .out_side ()
  );

  gcd_sincos #(.AFB(ANGLE_FRAC_BITS), .STAGES(CORDIC_STAGES), .SIDE_W(1)) u_sc_d (
    .clk (clk), .rst (rst), .in_valid (s0_valid), .angle (a_dl), .in_side (1'b0),
    .out_valid (), .sin_q (), .cos_q (ct), .out_side ()
  );

  // c = s1*s2 + (c1*c2)*cos(dlon), all Q60
  logic               mb_valid;
  logic signed [63:0] ss_p, cc_p, ct_d;
  logic [SW-1:0]      mb_side;

  gcd_mul #(.SHIFT(60), .SIDE_W(1)) u_mul_ss (
    .clk (clk), .rst (rst), .in_valid (sc_valid), .a (s1), .b (s2), .in_side (1'b0),
    .out_valid (), .p (ss_p), .out_side ()
  );

  gcd_mul #(.SHIFT(60), .SIDE_W(64 + SW)) u_mul_cc (
    .clk (clk), .rst (rst), .in_valid (sc_valid), .a (c1), .b (c2),
    .in_side ({ct, sc_side}),
    .out_valid (mb_valid), .p (cc_p), .out_side ({ct_d, mb_side})
  );

  logic               mc_valid;
  logic signed [63:0] ccc_p, ss_d;
  logic [SW-1:0]      mc_side;

  gcd_mul #(.SHIFT(60), .SIDE_W(64 + SW)) u_mul_cct (
    .clk (clk), .rst (rst), .in_valid (mb_valid), .a (cc_p), .b (ct_d),
    .in_side ({ss_p, mb_side}),
    .out_valid (mc_valid), .p (ccc_p), .out_side ({ss_d, mc_side})
  );

  // sum and clamp to [-1,1] to repair rounding
  logic signed [63:0] csum;
  logic               s1_valid;
  logic signed [63:0] c_cl;
  logic [SW-1:0]      s1_side;

  assign csum = ccc_p + ss_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= mc_valid;
    end
    if (csum > gcd_pkg::ONE_Q60)       c_cl <= gcd_pkg::ONE_Q60;
    else if (csum < -gcd_pkg::ONE_Q60) c_cl <= -gcd_pkg::ONE_Q60;
    else                               c_cl <= csum;
    s1_side <= mc_side;
  end

  // central angle in degrees
  logic               ac_valid;
  logic signed [63:0] ang;
  logic [SW-1:0]      ac_side;

  gcd_acos #(.STAGES(CORDIC_STAGES), .SIDE_W(SW)) u_acos (
    .clk (clk), .rst (rst), .in_valid (s1_valid), .cval (c_cl), .in_side (s1_side),
    .out_valid (ac_valid), .angle (ang), .out_side (ac_side)
  );

  // degrees Q55 times metres per degree Q27, back to whole metres
  logic               md_valid;
  logic signed [63:0] dist_p;
  logic [SW-1:0]      md_side;

  gcd_mul #(.SHIFT(82), .SIDE_W(SW)) u_mul_m (
    .clk (clk), .rst (rst), .in_valid (ac_valid), .a (ang), .b (gcd_pkg::M_PER_DEG),
    .in_side (ac_side),
    .out_valid (md_valid), .p (dist_p), .out_side (md_side)
  );

  // saturate, compare, output register
  logic [gcd_pkg::DIST_W-1:0] dist_sat;
  logic                       same_pt;
  logic [gcd_pkg::RAD_W-1:0]  radius;

  assign same_pt = md_side[SW-1];
  assign radius  = md_side[gcd_pkg::RAD_W-1:0];

  always_comb begin
    if (dist_p < 0)                      dist_sat = '0;
    else if (dist_p > gcd_pkg::DIST_MAX) dist_sat = '1;
    else                                 dist_sat = dist_p[gcd_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= md_valid;
    end
    if (same_pt) begin
      distance_m  <= '0;
      in_coverage <= 1'b1;
    end else begin
      distance_m  <= dist_sat;
      in_coverage <= (radius == gcd_pkg::RADIUS_ALL) || (dist_sat <= radius);
    end
  end

endmodule
